FILE: rtl/tzr_pkg.sv
// Shared types and constants for the thresholded zero-run encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
package tzr_pkg;

   localparam int ByteWidth = 8;
   localparam int CsrIndexWidth = 8;
   localparam int JobBytes = 3;

   localparam logic [CsrIndexWidth-1:0] CsrMinSend = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxSend = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CsrZeroRunLimit = 8'd2;

   localparam logic [ByteWidth-1:0] EscapeByte = 8'd0;
   localparam logic [ByteWidth-1:0] MinSendReset = 8'd1;
   localparam logic [ByteWidth-1:0] MaxSendReset = 8'd254;
   localparam logic [ByteWidth-1:0] ZeroRunLimitReset = 8'd255;

   typedef struct packed {
      logic [JobBytes-1:0][ByteWidth-1:0] bytes;
      logic [1:0] num;
   } job_type;

endpackage

FILE: rtl/thresholded_zero_run_encoder.sv
// Top level of the thresholded zero-run encoder.
// Instantiates tzr_front, tzr_queue and tzr_back; depends on tzr_pkg.
//
// Usage:
// The req channel carries one sample and a frame-end flag per transfer. The rsp
// channel carries one encoded byte per transfer, with last_of_run set on the
// final byte caused by a sample. Both channels use valid and stall.
// The csr channel writes min_send (index 0), max_send (index 1) and
// zero_run_limit (index 2); it is always ready, and other indexes are ignored.
// Write it only while the block is idle.
// A sample is classified in the cycle it is accepted and its bytes enter a
// two-entry queue; from there each byte passes through the output register to rsp.
// The serializer sends one byte per cycle while rsp does not stall, and a sample
// yields up to three bytes; a sample with no bytes puts no job in the queue.
// When rsp stalls, the output register holds its byte, the queue fills and
// req_stall rises once both entries are occupied.
// Reset restores the register defaults, clears the run count and empties the
// queue and output register.
module thresholded_zero_run_encoder (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [tzr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [tzr_pkg::ByteWidth-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [tzr_pkg::ByteWidth-1:0] req_sample,
   input  logic req_frame_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [tzr_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic rsp_last_of_run
);

   logic push;
   logic pop;
   logic queue_full;
   logic head_valid;
   tzr_pkg::job_type push_job;
   tzr_pkg::job_type head_job;

   tzr_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_frame_end(req_frame_end),
      .queue_full(queue_full),
      .push(push),
      .push_job(push_job)
   );

   tzr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .full(queue_full),
      .pop(pop),
      .head_valid(head_valid),
      .head_job(head_job)
   );

   tzr_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_job(head_job),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

FILE: rtl/tzr_front.sv
// Front end: configuration registers, run counter and classification of each sample.
// Pushes one job of up to three bytes per sample that yields any; depends on tzr_pkg.
module tzr_front (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [tzr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [tzr_pkg::ByteWidth-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [tzr_pkg::ByteWidth-1:0] req_sample,
   input  logic req_frame_end,
   input  logic queue_full,
   output logic push,
   output tzr_pkg::job_type push_job
);

   logic [tzr_pkg::ByteWidth-1:0] min_send_ff;
   logic [tzr_pkg::ByteWidth-1:0] max_send_ff;
   logic [tzr_pkg::ByteWidth-1:0] limit_ff;
   logic [tzr_pkg::ByteWidth-1:0] count_ff;
   logic [tzr_pkg::ByteWidth-1:0] count_in;
   logic [tzr_pkg::ByteWidth-1:0] run_count;
   logic [tzr_pkg::ByteWidth-1:0] run_len;
   logic [tzr_pkg::ByteWidth-1:0] send_byte;
   logic [tzr_pkg::ByteWidth:0] count_plus;
   logic below;
   logic run_pair;
   logic send;
   logic flush_pair;
   logic accept;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;

   always_comb begin
      below = req_sample < min_send_ff;
      count_plus = {1'b0, count_ff} + {{tzr_pkg::ByteWidth{1'b0}}, 1'b1};
      run_pair = 1'b0;
      run_len = count_ff;
      run_count = count_ff;
      if (below) begin
         if (count_plus >= {1'b0, limit_ff}) begin
            run_pair = 1'b1;
            run_len = limit_ff;
            run_count = '0;
         end else begin
            run_count = count_plus[tzr_pkg::ByteWidth-1:0];
         end
      end else if (count_ff != '0) begin
         run_pair = 1'b1;
         run_count = '0;
      end

      send = 1'b1;
      send_byte = req_sample;
      if (req_sample > max_send_ff) begin
         send_byte = max_send_ff;
      end else if (below) begin
         send = 1'b0;
      end

      flush_pair = req_frame_end && (run_count != '0);
      count_in = flush_pair ? '0 : run_count;

      push_job.num = 2'({1'b0, run_pair} + {1'b0, run_pair} + {1'b0, send}
                        + {1'b0, flush_pair} + {1'b0, flush_pair});
      if (run_pair) begin
         push_job.bytes[0] = tzr_pkg::EscapeByte;
         push_job.bytes[1] = run_len;
         push_job.bytes[2] = send_byte;
      end else if (send) begin
         push_job.bytes[0] = send_byte;
         push_job.bytes[1] = tzr_pkg::EscapeByte;
         push_job.bytes[2] = run_count;
      end else begin
         push_job.bytes[0] = tzr_pkg::EscapeByte;
         push_job.bytes[1] = run_count;
         push_job.bytes[2] = run_count;
      end
      push = accept && (push_job.num != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_send_ff <= tzr_pkg::MinSendReset;
         max_send_ff <= tzr_pkg::MaxSendReset;
         limit_ff <= tzr_pkg::ZeroRunLimitReset;
         count_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tzr_pkg::CsrMinSend: min_send_ff <= csr_data;
               tzr_pkg::CsrMaxSend: max_send_ff <= csr_data;
               tzr_pkg::CsrZeroRunLimit: limit_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

endmodule

FILE: rtl/tzr_queue.sv
// Two-entry job queue between the front end and the byte serializer.
// Depends on tzr_pkg for the job type.
module tzr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  tzr_pkg::job_type push_job,
   output logic full,
   input  logic pop,
   output logic head_valid,
   output tzr_pkg::job_type head_job
);

   tzr_pkg::job_type entry_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign full = fill_ff == 2'd2;
   assign head_valid = fill_ff != 2'd0;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: rtl/tzr_back.sv
// Back end: sends the bytes of the head job one per transfer through an output register.
// Depends on tzr_pkg for the job type.
module tzr_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  tzr_pkg::job_type head_job,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [tzr_pkg::ByteWidth-1:0] rsp_out_byte,
   output logic rsp_last_of_run
);

   logic [1:0] pos_ff;
   logic rsp_valid_ff;
   logic [tzr_pkg::ByteWidth-1:0] out_byte_ff;
   logic last_ff;
   logic out_free;
   logic is_last;
   logic [tzr_pkg::ByteWidth-1:0] cur_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      is_last = pos_ff == (head_job.num - 2'd1);
      pop = out_free && head_valid && is_last;
      case (pos_ff)
         2'd0: cur_byte = head_job.bytes[0];
         2'd1: cur_byte = head_job.bytes[1];
         default: cur_byte = head_job.bytes[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_byte_ff <= cur_byte;
         last_ff <= is_last;
      end
      if (reset) begin
         pos_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) begin
            pos_ff <= is_last ? 2'd0 : pos_ff + 2'd1;
         end
      end
   end

endmodule

FILE: tb/tb_thresholded_zero_run_encoder.sv
// Self-checking testbench for thresholded_zero_run_encoder: directed and random
// sample streams under several threshold and run-limit settings, with random
// idle and stall bursts on both channels. Depends on tzr_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_thresholded_zero_run_encoder;

   typedef logic [tzr_pkg::ByteWidth-1:0] byte_type;

   localparam logic [tzr_pkg::CsrIndexWidth-1:0] CsrSpareLow = 8'd3;
   localparam logic [tzr_pkg::CsrIndexWidth-1:0] CsrSpareHigh = 8'd255;

   typedef struct {
      logic [tzr_pkg::ByteWidth-1:0] sample;
      logic frame_end;
   } sample_item_type;

   typedef struct {
      logic [tzr_pkg::ByteWidth-1:0] out_byte;
      logic last_of_run;
   } coded_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tzr_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [tzr_pkg::ByteWidth-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [tzr_pkg::ByteWidth-1:0] req_sample = '0;
   logic req_frame_end = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [tzr_pkg::ByteWidth-1:0] rsp_out_byte;
   logic rsp_last_of_run;

   sample_item_type sample_queue[$];
   coded_byte_type expected_bytes[$];

   logic [tzr_pkg::ByteWidth-1:0] min_send_cfg;
   logic [tzr_pkg::ByteWidth-1:0] max_send_cfg;
   logic [tzr_pkg::ByteWidth-1:0] run_limit_cfg;
   logic [tzr_pkg::ByteWidth-1:0] run_count;

   int mismatches = 0;
   int req_idle_odds = 6;
   int rsp_stall_odds = 6;
   int req_gap = 0;
   int rsp_hold = 0;

   thresholded_zero_run_encoder dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Works out the bytes one accepted sample produces and updates the run count.
   function automatic void encode_sample(input logic [tzr_pkg::ByteWidth-1:0] sample,
                                         input logic frame_end);
      logic [tzr_pkg::ByteWidth-1:0] coded [3];
      coded_byte_type entry;
      int n;
      n = 0;
      if (sample < min_send_cfg) begin
         if (int'(run_count) + 1 >= int'(run_limit_cfg)) begin
            coded[n] = tzr_pkg::EscapeByte;
            coded[n + 1] = run_limit_cfg;
            n = n + 2;
            run_count = '0;
         end else begin
            run_count = run_count + 8'd1;
         end
      end else if (run_count > 0) begin
         coded[n] = tzr_pkg::EscapeByte;
         coded[n + 1] = run_count;
         n = n + 2;
         run_count = '0;
      end
      if (sample > max_send_cfg) begin
         coded[n] = max_send_cfg;
         n = n + 1;
      end else if (sample >= min_send_cfg) begin
         coded[n] = sample;
         n = n + 1;
      end
      if (frame_end && run_count > 0) begin
         coded[n] = tzr_pkg::EscapeByte;
         coded[n + 1] = run_count;
         n = n + 2;
         run_count = '0;
      end
      for (int i = 0; i < n; i++) begin
         entry.out_byte = coded[i];
         entry.last_of_run = (i == n - 1);
         expected_bytes.push_back(entry);
      end
   endfunction

   // Sample driver: holds each transfer until accepted, with random idle bursts.
   always @(posedge clock) begin
      sample_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_sample(req_sample, req_frame_end);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (req_idle_odds > 0 && $urandom_range(0, req_idle_odds - 1) == 0) begin
               req_gap = $urandom_range(1, 11) - 1;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               item = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_sample <= item.sample;
               req_frame_end <= item.frame_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each byte transfer against the oldest expectation.
   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected byte %0d last %0b", $realtime, rsp_out_byte,
                           rsp_last_of_run);
               end
            end else begin
               want = expected_bytes.pop_front();
               if (want.out_byte !== rsp_out_byte || want.last_of_run !== rsp_last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: byte expected %0d last %0b, got %0d last %0b", $realtime,
                              want.out_byte, want.last_of_run, rsp_out_byte, rsp_last_of_run);
                  end
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_stall_odds > 0 && $urandom_range(0, rsp_stall_odds - 1) == 0) begin
            rsp_hold = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_item(input logic [tzr_pkg::ByteWidth-1:0] sample,
                            input logic frame_end);
      sample_item_type item;
      item.sample = sample;
      item.frame_end = frame_end;
      sample_queue.push_back(item);
   endtask

   // Mostly runs of below-threshold samples broken by sent samples and frame ends.
   task automatic push_random_items(input int count);
      logic [tzr_pkg::ByteWidth-1:0] sample;
      for (int i = 0; i < count; i++) begin
         if (min_send_cfg > 0 && $urandom_range(0, 1) == 1) begin
            sample = byte_type'($urandom_range(0, int'(min_send_cfg) - 1));
         end else begin
            sample = byte_type'($urandom_range(0, 255));
         end
         push_item(sample, $urandom_range(0, 7) == 0);
      end
   endtask

   // Called at a rising edge; leaves csr_valid high for a following write.
   task automatic csr_write(input logic [tzr_pkg::CsrIndexWidth-1:0] index,
                            input logic [tzr_pkg::ByteWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         tzr_pkg::CsrMinSend: min_send_cfg = data;
         tzr_pkg::CsrMaxSend: max_send_cfg = data;
         tzr_pkg::CsrZeroRunLimit: run_limit_cfg = data;
         default: ;
      endcase
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   // Waits until every sample is accepted and every byte has arrived, then
   // lets the pipeline settle so that a sample with no bytes has cleared it.
   task automatic wait_drained();
      do @(negedge clock);
      while (!(sample_queue.size() == 0 && !req_valid && expected_bytes.size() == 0));
      repeat (10) @(posedge clock);
   endtask

   initial begin
      min_send_cfg = tzr_pkg::MinSendReset;
      max_send_cfg = tzr_pkg::MaxSendReset;
      run_limit_cfg = tzr_pkg::ZeroRunLimitReset;
      run_count = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_item(8'd0, 1'b0);
      push_item(8'd0, 1'b0);
      push_item(8'hAA, 1'b0);
      push_item(8'd255, 1'b0);
      push_item(8'd0, 1'b1);
      push_item(8'd1, 1'b1);
      wait_drained();

      // Crossed thresholds, plus writes to indexes that hold no register.
      csr_write(tzr_pkg::CsrMinSend, 8'd200);
      csr_write(tzr_pkg::CsrMaxSend, 8'd100);
      csr_write(CsrSpareLow, 8'h55);
      csr_write(CsrSpareHigh, 8'hAA);
      csr_done();
      push_item(8'd150, 1'b0);
      push_item(8'd50, 1'b0);
      push_item(8'd250, 1'b1);
      push_item(8'd0, 1'b1);
      wait_drained();

      csr_write(tzr_pkg::CsrMinSend, 8'd16);
      csr_write(tzr_pkg::CsrMaxSend, 8'd254);
      csr_write(tzr_pkg::CsrZeroRunLimit, 8'd1);
      csr_done();
      push_item(8'd3, 1'b0);
      push_item(8'd16, 1'b1);
      push_item(8'd15, 1'b1);
      wait_drained();

      csr_write(tzr_pkg::CsrZeroRunLimit, 8'd0);
      csr_done();
      push_item(8'd0, 1'b0);
      push_item(8'd20, 1'b1);
      wait_drained();

      // A pending run longer than the limit that is written next.
      csr_write(tzr_pkg::CsrMinSend, 8'd1);
      csr_write(tzr_pkg::CsrZeroRunLimit, 8'd255);
      csr_done();
      repeat (4) push_item(8'd0, 1'b0);
      wait_drained();
      csr_write(tzr_pkg::CsrZeroRunLimit, 8'd3);
      csr_done();
      push_item(8'd0, 1'b0);
      push_item(8'd0, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(tzr_pkg::CsrMinSend, 8'd0);
               csr_write(tzr_pkg::CsrMaxSend, 8'd0);
               csr_write(tzr_pkg::CsrZeroRunLimit, 8'd1);
            end
            1: begin
               csr_write(tzr_pkg::CsrMinSend, 8'd255);
               csr_write(tzr_pkg::CsrMaxSend, 8'd254);
               csr_write(tzr_pkg::CsrZeroRunLimit, 8'd255);
            end
            2: begin
               csr_write(tzr_pkg::CsrMinSend, 8'd255);
               csr_write(tzr_pkg::CsrMaxSend, 8'd0);
               csr_write(tzr_pkg::CsrZeroRunLimit, 8'd3);
            end
            default: begin
               csr_write(tzr_pkg::CsrMinSend, byte_type'($urandom_range(0, 255)));
               csr_write(tzr_pkg::CsrMaxSend, byte_type'($urandom_range(0, 254)));
               csr_write(tzr_pkg::CsrZeroRunLimit,
                         byte_type'($urandom_range(0, 3) == 0 ?
                                    $urandom_range(1, 255) : $urandom_range(1, 8)));
            end
         endcase
         csr_done();
         req_idle_odds = (phase == 3 || phase == 5) ? 0 : $urandom_range(2, 8);
         rsp_stall_odds = (phase == 3 || phase == 5) ? 0 : $urandom_range(2, 8);
         push_random_items(34);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tzr_pkg.sv
rtl/tzr_front.sv
rtl/tzr_queue.sv
rtl/tzr_back.sv
rtl/thresholded_zero_run_encoder.sv
tb/tb_thresholded_zero_run_encoder.sv
